FILE: rtl/oae_pkg.sv
// Shared constants, codes and controller/datapath interface types for the ordered array engine.
package oae_pkg;

  localparam int DEPTH  = 64;
  localparam int ITEM_W = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int IDX_W  = 7;
  localparam int IDX2_W = 6;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_GET     = 3'd2;
  localparam logic [OP_W-1:0] OP_PUT     = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP    = 3'd4;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;
  localparam logic [OP_W-1:0] OP_SORT    = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd7;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {R_A, R_B, R_AM1, R_AP1} rsel_e;
  typedef enum logic [2:0] {W_NONE, W_A_DATA, W_A_RD, W_A_SWAP, W_B_VA} wsel_e;
  typedef enum logic [3:0] {
    P_HOLD, P_LOAD, P_DEC_A, P_INC_A, P_REV, P_FWD, P_BWD, P_TURN_F, P_TURN_B
  } pop_e;

  typedef struct packed {
    rsel_e rd;
    wsel_e wr;
    pop_e  ptr;
    logic  cap;
    logic  fin;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic            full;
    logic            cnt_gt1;
    logic            a_gt_u;
    logic            ap1_lt_cnt;
    logic            a_lt_b;
    logic            a_lt_hi;
    logic            b_gt_lo;
    logic            turn_go;
    logic            dir_bwd;
  } stat_t;

endpackage

FILE: rtl/oae_ram.sv
// Generic single write port, single read port RAM with registered read data.
module oae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/oae_dp.sv
// Datapath: request registers, pointers, item memory, comparator and result registers.
module oae_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  oae_pkg::cmd_t                 cmd_i,
  output oae_pkg::stat_t                stat_o,
  input  logic [oae_pkg::OP_W-1:0]      op_i,
  input  logic [oae_pkg::IDX_W-1:0]     index_i,
  input  logic [oae_pkg::IDX2_W-1:0]    second_index_i,
  input  logic [oae_pkg::ITEM_W-1:0]    write_data_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          done_o,
  output logic [oae_pkg::ST_W-1:0]      status_o,
  output logic [oae_pkg::ITEM_W-1:0]    read_data_o,
  output logic [oae_pkg::AW-1:0]        position_o,
  output logic [oae_pkg::CW-1:0]        item_count_o
);

  localparam logic [oae_pkg::ITEM_W-1:0] SIGN_BIT = {1'b1, {(oae_pkg::ITEM_W-1){1'b0}}};

  logic [oae_pkg::OP_W-1:0]   op_q;
  logic                       bad_q, full_q, swap_q, moved_q, dir_q, cfg_q, done_q;
  logic [oae_pkg::AW-1:0]     u_q, a_q, b_q, lo_q, hi_q;
  logic [oae_pkg::ITEM_W-1:0] wdata_q, va_q;
  logic [oae_pkg::CW-1:0]     cnt_q, cnt_d;

  logic                       neg, append, in_rng, bad_ld, full_ld;
  logic [oae_pkg::CW-1:0]     mag, sec;
  logic [oae_pkg::AW-1:0]     u_ld, a_ld, b_ld;

  logic                       ram_we;
  logic [oae_pkg::AW-1:0]     ram_waddr, ram_raddr;
  logic [oae_pkg::ITEM_W-1:0] ram_wdata, ram_rd, sgn;
  logic                       gt, swap_cond, ok_ins, ok_rd;

  oae_ram #(.WIDTH(oae_pkg::ITEM_W), .DEPTH(oae_pkg::DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rd)
  );

  // Request checks, evaluated on the incoming fields while the request is taken.
  always_comb begin
    neg     = index_i[oae_pkg::IDX_W-1];
    append  = (index_i == '1);
    mag     = oae_pkg::CW'(index_i[oae_pkg::IDX_W-2:0]);
    sec     = oae_pkg::CW'(second_index_i);
    in_rng  = !neg && (mag < cnt_q);
    u_ld    = index_i[oae_pkg::AW-1:0];
    bad_ld  = 1'b0;
    full_ld = 1'b0;
    unique case (op_i)
      oae_pkg::OP_INSERT: begin
        bad_ld  = !append && (neg || (mag > cnt_q));
        full_ld = !bad_ld && (cnt_q == oae_pkg::CW'(oae_pkg::DEPTH));
        if (append) begin
          u_ld = cnt_q[oae_pkg::AW-1:0];
        end
      end
      oae_pkg::OP_REMOVE, oae_pkg::OP_GET, oae_pkg::OP_PUT: bad_ld = !in_rng;
      oae_pkg::OP_SWAP: bad_ld = !in_rng || (sec >= cnt_q);
      default: bad_ld = 1'b0;
    endcase
    if (op_i == oae_pkg::OP_INSERT) begin
      a_ld = cnt_q[oae_pkg::AW-1:0];
    end else if (op_i == oae_pkg::OP_REVERSE || op_i == oae_pkg::OP_SORT) begin
      a_ld = '0;
    end else begin
      a_ld = u_ld;
    end
    if (op_i == oae_pkg::OP_SWAP) begin
      b_ld = second_index_i[oae_pkg::AW-1:0];
    end else if (op_i == oae_pkg::OP_REVERSE) begin
      b_ld = cnt_q[oae_pkg::AW-1:0] - oae_pkg::AW'(1);
    end else begin
      b_ld = oae_pkg::AW'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.rd)
      oae_pkg::R_A:   ram_raddr = a_q;
      oae_pkg::R_B:   ram_raddr = b_q;
      oae_pkg::R_AM1: ram_raddr = a_q - oae_pkg::AW'(1);
      oae_pkg::R_AP1: ram_raddr = a_q + oae_pkg::AW'(1);
      default:        ram_raddr = a_q;
    endcase
  end

  // Flipping the sign bit lets an unsigned compare order two's complement values.
  assign sgn       = cfg_q ? SIGN_BIT : '0;
  assign gt        = (va_q ^ sgn) > (ram_rd ^ sgn);
  assign swap_cond = (op_q == oae_pkg::OP_SORT) ? gt : 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_q;
    ram_wdata = ram_rd;
    unique case (cmd_i.wr)
      oae_pkg::W_NONE:   ram_we = 1'b0;
      oae_pkg::W_A_DATA: begin
        ram_we    = 1'b1;
        ram_wdata = wdata_q;
      end
      oae_pkg::W_A_RD:   ram_we = 1'b1;
      oae_pkg::W_A_SWAP: ram_we = swap_cond;
      oae_pkg::W_B_VA: begin
        ram_we    = swap_q;
        ram_waddr = b_q;
        ram_wdata = va_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ok_ins = (op_q == oae_pkg::OP_INSERT) && !bad_q && !full_q;
  assign ok_rd  = !bad_q && (op_q == oae_pkg::OP_GET || op_q == oae_pkg::OP_REMOVE);

  always_comb begin
    cnt_d = cnt_q;
    if (ok_ins) begin
      cnt_d = cnt_q + oae_pkg::CW'(1);
    end else if (op_q == oae_pkg::OP_REMOVE && !bad_q) begin
      cnt_d = cnt_q - oae_pkg::CW'(1);
    end else if (op_q == oae_pkg::OP_CLEAR) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.bad        = bad_q;
    stat_o.full       = full_q;
    stat_o.cnt_gt1    = cnt_q > oae_pkg::CW'(1);
    stat_o.a_gt_u     = a_q > u_q;
    stat_o.ap1_lt_cnt = (oae_pkg::CW'(a_q) + oae_pkg::CW'(1)) < cnt_q;
    stat_o.a_lt_b     = a_q < b_q;
    stat_o.a_lt_hi    = a_q < hi_q;
    stat_o.b_gt_lo    = b_q > lo_q;
    stat_o.turn_go    = moved_q && ((oae_pkg::CW'(lo_q) + oae_pkg::CW'(1)) < oae_pkg::CW'(hi_q));
    stat_o.dir_bwd    = dir_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cfg_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.fin) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      va_q <= ram_rd;
    end
    if (cmd_i.wr == oae_pkg::W_A_SWAP) begin
      swap_q  <= swap_cond;
      moved_q <= moved_q | swap_cond;
    end
    unique case (cmd_i.ptr)
      oae_pkg::P_HOLD: ;
      oae_pkg::P_LOAD: begin
        op_q    <= op_i;
        bad_q   <= bad_ld;
        full_q  <= full_ld;
        u_q     <= u_ld;
        wdata_q <= write_data_i;
        a_q     <= a_ld;
        b_q     <= b_ld;
        lo_q    <= '0;
        hi_q    <= cnt_q[oae_pkg::AW-1:0] - oae_pkg::AW'(1);
        moved_q <= 1'b0;
        dir_q   <= 1'b0;
      end
      oae_pkg::P_DEC_A: a_q <= a_q - oae_pkg::AW'(1);
      oae_pkg::P_INC_A: a_q <= a_q + oae_pkg::AW'(1);
      oae_pkg::P_REV: begin
        a_q <= a_q + oae_pkg::AW'(1);
        b_q <= b_q - oae_pkg::AW'(1);
      end
      oae_pkg::P_FWD: begin
        a_q <= a_q + oae_pkg::AW'(1);
        b_q <= b_q + oae_pkg::AW'(1);
      end
      oae_pkg::P_BWD: begin
        a_q <= a_q - oae_pkg::AW'(1);
        b_q <= b_q - oae_pkg::AW'(1);
      end
      oae_pkg::P_TURN_F: begin
        hi_q    <= hi_q - oae_pkg::AW'(1);
        a_q     <= hi_q - oae_pkg::AW'(2);
        b_q     <= hi_q - oae_pkg::AW'(1);
        moved_q <= 1'b0;
        dir_q   <= 1'b1;
      end
      oae_pkg::P_TURN_B: begin
        lo_q    <= lo_q + oae_pkg::AW'(1);
        a_q     <= lo_q + oae_pkg::AW'(1);
        b_q     <= lo_q + oae_pkg::AW'(2);
        moved_q <= 1'b0;
        dir_q   <= 1'b0;
      end
      default: ;
    endcase
    if (cmd_i.fin) begin
      status_o     <= bad_q ? oae_pkg::ST_BAD_INDEX :
                      (full_q ? oae_pkg::ST_FULL : oae_pkg::ST_OK);
      read_data_o  <= ok_rd ? va_q : '0;
      position_o   <= ok_ins ? u_q : '0;
      item_count_o <= cnt_d;
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/oae_ctrl.sv
// Controller state machine that sequences memory reads and writes for each request.
module oae_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  oae_pkg::stat_t stat_i,
  output oae_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_INS_T = 4'd2;
  localparam logic [3:0] S_INS_W = 4'd3;
  localparam logic [3:0] S_REM_C = 4'd4;
  localparam logic [3:0] S_REM_T = 4'd5;
  localparam logic [3:0] S_REM_W = 4'd6;
  localparam logic [3:0] S_GET_C = 4'd7;
  localparam logic [3:0] S_PR_RA = 4'd8;
  localparam logic [3:0] S_PR_RB = 4'd9;
  localparam logic [3:0] S_PR_WA = 4'd10;
  localparam logic [3:0] S_PR_WB = 4'd11;
  localparam logic [3:0] S_REV_T = 4'd12;
  localparam logic [3:0] S_SRT_F = 4'd13;
  localparam logic [3:0] S_SRT_B = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.rd  = oae_pkg::R_A;
    cmd_o.wr  = oae_pkg::W_NONE;
    cmd_o.ptr = oae_pkg::P_HOLD;
    cmd_o.cap = 1'b0;
    cmd_o.fin = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.ptr = oae_pkg::P_LOAD;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.bad || stat_i.full) begin
          state_d = S_FIN;
        end else begin
          unique case (stat_i.op)
            oae_pkg::OP_INSERT: state_d = S_INS_T;
            oae_pkg::OP_REMOVE: state_d = S_REM_C;
            oae_pkg::OP_GET:    state_d = S_GET_C;
            oae_pkg::OP_PUT: begin
              cmd_o.wr = oae_pkg::W_A_DATA;
              state_d  = S_FIN;
            end
            oae_pkg::OP_SWAP:    state_d = S_PR_RA;
            oae_pkg::OP_REVERSE: state_d = stat_i.cnt_gt1 ? S_REV_T : S_FIN;
            oae_pkg::OP_SORT:    state_d = stat_i.cnt_gt1 ? S_SRT_F : S_FIN;
            default:             state_d = S_FIN;
          endcase
        end
      end
      S_INS_T: begin
        if (stat_i.a_gt_u) begin
          cmd_o.rd = oae_pkg::R_AM1;
          state_d  = S_INS_W;
        end else begin
          cmd_o.wr = oae_pkg::W_A_DATA;
          state_d  = S_FIN;
        end
      end
      S_INS_W: begin
        cmd_o.wr  = oae_pkg::W_A_RD;
        cmd_o.ptr = oae_pkg::P_DEC_A;
        state_d   = S_INS_T;
      end
      S_REM_C: begin
        cmd_o.cap = 1'b1;
        state_d   = S_REM_T;
      end
      S_REM_T: begin
        if (stat_i.ap1_lt_cnt) begin
          cmd_o.rd = oae_pkg::R_AP1;
          state_d  = S_REM_W;
        end else begin
          state_d = S_FIN;
        end
      end
      S_REM_W: begin
        cmd_o.wr  = oae_pkg::W_A_RD;
        cmd_o.ptr = oae_pkg::P_INC_A;
        state_d   = S_REM_T;
      end
      S_GET_C: begin
        cmd_o.cap = 1'b1;
        state_d   = S_FIN;
      end
      S_PR_RA: state_d = S_PR_RB;
      S_PR_RB: begin
        cmd_o.rd  = oae_pkg::R_B;
        cmd_o.cap = 1'b1;
        state_d   = S_PR_WA;
      end
      S_PR_WA: begin
        cmd_o.wr = oae_pkg::W_A_SWAP;
        state_d  = S_PR_WB;
      end
      S_PR_WB: begin
        cmd_o.wr = oae_pkg::W_B_VA;
        if (stat_i.op == oae_pkg::OP_SWAP) begin
          state_d = S_FIN;
        end else if (stat_i.op == oae_pkg::OP_REVERSE) begin
          cmd_o.ptr = oae_pkg::P_REV;
          state_d   = S_REV_T;
        end else if (stat_i.dir_bwd) begin
          cmd_o.ptr = oae_pkg::P_BWD;
          state_d   = S_SRT_B;
        end else begin
          cmd_o.ptr = oae_pkg::P_FWD;
          state_d   = S_SRT_F;
        end
      end
      S_REV_T: state_d = stat_i.a_lt_b ? S_PR_RA : S_FIN;
      S_SRT_F: begin
        if (stat_i.a_lt_hi) begin
          state_d = S_PR_RA;
        end else begin
          cmd_o.ptr = oae_pkg::P_TURN_F;
          state_d   = stat_i.turn_go ? S_SRT_B : S_FIN;
        end
      end
      S_SRT_B: begin
        if (stat_i.b_gt_lo) begin
          state_d = S_PR_RA;
        end else begin
          cmd_o.ptr = oae_pkg::P_TURN_B;
          state_d   = stat_i.turn_go ? S_SRT_F : S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ordered_array_engine_core.sv
// Top level of the ordered array engine: controller, datapath and checks.
//
//  channel   handshake            payload
//  request   start / busy         op_i, index_i, second_index_i, write_data_i
//  result    done_o (one cycle)   status_o, read_data_o, position_o, item_count_o
//  config    cfg_we_i             cfg_wdata_i (compare_signed)
//
// One request is worked at a time through a single-port-read item memory.
// Get, put, clear and rejected requests move no items; insert and remove shift items
// one at a time, swap exchanges two items, reverse swaps pairs inward, and sort runs
// shaker passes. No clearing pass runs after reset; the count alone starts at zero.
// The result strobe cannot be stalled by the receiver.
module ordered_array_engine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [oae_pkg::OP_W-1:0]      op_i,
  input  logic [oae_pkg::IDX_W-1:0]     index_i,
  input  logic [oae_pkg::IDX2_W-1:0]    second_index_i,
  input  logic [oae_pkg::ITEM_W-1:0]    write_data_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          done_o,
  output logic [oae_pkg::ST_W-1:0]      status_o,
  output logic [oae_pkg::ITEM_W-1:0]    read_data_o,
  output logic [oae_pkg::AW-1:0]        position_o,
  output logic [oae_pkg::CW-1:0]        item_count_o
);

  oae_pkg::cmd_t  cmd;
  oae_pkg::stat_t stat;

  oae_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  oae_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .index_i        (index_i),
    .second_index_i (second_index_i),
    .write_data_i   (write_data_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .read_data_o    (read_data_o),
    .position_o     (position_o),
    .item_count_o   (item_count_o)
  );

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but engine not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != 2'd3))
    else $error("undefined status code");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (item_count_o <= oae_pkg::CW'(oae_pkg::DEPTH)))
    else $error("item count above depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != oae_pkg::ST_OK)) |-> (read_data_o == '0 && position_o == '0))
    else $error("failed request returned data");

endmodule

FILE: sim/tb_top.sv
// Testbench for the ordered array engine: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [oae_pkg::OP_W-1:0]   op;
    logic [oae_pkg::IDX_W-1:0]  idx;
    logic [oae_pkg::IDX2_W-1:0] idx2;
    logic [oae_pkg::ITEM_W-1:0] data;
  } array_req_t;

  typedef struct {
    logic [oae_pkg::ST_W-1:0]   status;
    logic [oae_pkg::ITEM_W-1:0] rdata;
    logic [oae_pkg::AW-1:0]     pos;
    logic [oae_pkg::CW-1:0]     count;
  } array_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [oae_pkg::OP_W-1:0] op_i = oae_pkg::OP_GET;
  logic [oae_pkg::IDX_W-1:0] index_i = '0;
  logic [oae_pkg::IDX2_W-1:0] second_index_i = '0;
  logic [oae_pkg::ITEM_W-1:0] write_data_i = '0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic done_o;
  logic [oae_pkg::ST_W-1:0] status_o;
  logic [oae_pkg::ITEM_W-1:0] read_data_o;
  logic [oae_pkg::AW-1:0] position_o;
  logic [oae_pkg::CW-1:0] item_count_o;

  ordered_array_engine_core uut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .index_i, .second_index_i, .write_data_i,
    .cfg_we_i, .cfg_wdata_i, .done_o, .status_o, .read_data_o, .position_o, .item_count_o
  );

  array_req_t pending_reqs[$];
  array_rsp_t expected_rsps[$];
  logic [oae_pkg::ITEM_W-1:0] mirror_items [oae_pkg::DEPTH];
  int mirror_count = 0;
  bit mirror_signed = 1'b0;
  int plan_count = 0;
  int idle_pct = 0;
  int mismatches = 0;
  bit taken = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #240_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit item_above(logic [oae_pkg::ITEM_W-1:0] a,
                                    logic [oae_pkg::ITEM_W-1:0] b);
    if (mirror_signed) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  function automatic void swap_mirror(int a, int b);
    logic [oae_pkg::ITEM_W-1:0] t;
    t = mirror_items[a];
    mirror_items[a] = mirror_items[b];
    mirror_items[b] = t;
  endfunction

  function automatic void shaker_sort_mirror();
    int lo;
    int hi;
    bit moved;
    lo = 0;
    hi = mirror_count - 1;
    moved = 1'b1;
    if (mirror_count < 2) return;
    while (moved && lo < hi) begin
      moved = 1'b0;
      for (int i = lo; i < hi; i++) begin
        if (item_above(mirror_items[i], mirror_items[i+1])) begin
          swap_mirror(i, i + 1);
          moved = 1'b1;
        end
      end
      hi--;
      if (!moved || lo >= hi) break;
      moved = 1'b0;
      for (int i = hi; i > lo; i--) begin
        if (item_above(mirror_items[i-1], mirror_items[i])) begin
          swap_mirror(i - 1, i);
          moved = 1'b1;
        end
      end
      lo++;
    end
  endfunction

  // Applies one request to the mirror array and returns the result it should give.
  function automatic array_rsp_t apply_array_op(array_req_t r);
    array_rsp_t rsp;
    int idx;
    int u;
    bit in_range;
    idx = $signed(r.idx);
    in_range = (idx >= 0) && (idx < mirror_count);
    u = (idx >= 0) ? idx : 0;
    rsp.status = oae_pkg::ST_OK;
    rsp.rdata = '0;
    rsp.pos = '0;
    case (r.op)
      oae_pkg::OP_INSERT: begin
        if (idx == -1) u = mirror_count;
        if (idx != -1 && (idx < 0 || u > mirror_count)) rsp.status = oae_pkg::ST_BAD_INDEX;
        else if (mirror_count >= oae_pkg::DEPTH) rsp.status = oae_pkg::ST_FULL;
        else begin
          for (int i = mirror_count; i > u; i--) mirror_items[i] = mirror_items[i-1];
          mirror_items[u] = r.data;
          mirror_count++;
          rsp.pos = u[oae_pkg::AW-1:0];
        end
      end
      oae_pkg::OP_REMOVE: begin
        if (!in_range) rsp.status = oae_pkg::ST_BAD_INDEX;
        else begin
          rsp.rdata = mirror_items[u];
          for (int i = u; i + 1 < mirror_count; i++) mirror_items[i] = mirror_items[i+1];
          mirror_count--;
        end
      end
      oae_pkg::OP_GET: begin
        if (!in_range) rsp.status = oae_pkg::ST_BAD_INDEX;
        else rsp.rdata = mirror_items[u];
      end
      oae_pkg::OP_PUT: begin
        if (!in_range) rsp.status = oae_pkg::ST_BAD_INDEX;
        else mirror_items[u] = r.data;
      end
      oae_pkg::OP_SWAP: begin
        if (!in_range || r.idx2 >= mirror_count) rsp.status = oae_pkg::ST_BAD_INDEX;
        else swap_mirror(u, r.idx2);
      end
      oae_pkg::OP_REVERSE: begin
        for (int b = 0; b < mirror_count - 1 - b; b++) swap_mirror(b, mirror_count - 1 - b);
      end
      oae_pkg::OP_SORT: shaker_sort_mirror();
      default: mirror_count = 0;
    endcase
    rsp.count = mirror_count[oae_pkg::CW-1:0];
    return rsp;
  endfunction

  // Queues a request and tracks the count it will leave, which depends only on op, index and the count before it.
  task automatic queue_req(logic [oae_pkg::OP_W-1:0] op, logic [oae_pkg::IDX_W-1:0] idx,
                           logic [oae_pkg::IDX2_W-1:0] idx2,
                           logic [oae_pkg::ITEM_W-1:0] data);
    array_req_t r;
    int i;
    r.op = op;
    r.idx = idx;
    r.idx2 = idx2;
    r.data = data;
    i = $signed(idx);
    pending_reqs.push_back(r);
    if (op == oae_pkg::OP_INSERT && (i == -1 || (i >= 0 && i <= plan_count)) &&
        plan_count < oae_pkg::DEPTH)
      plan_count++;
    else if (op == oae_pkg::OP_REMOVE && i >= 0 && i < plan_count) plan_count--;
    else if (op == oae_pkg::OP_CLEAR) plan_count = 0;
  endtask

  function automatic logic [oae_pkg::ITEM_W-1:0] rand_item();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(oae_pkg::ITEM_W-1){1'b0}}};
      3: return {1'b0, {(oae_pkg::ITEM_W-1){1'b1}}};
      4: return oae_pkg::ITEM_W'($urandom_range(0, 15));
      default: return oae_pkg::ITEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [oae_pkg::IDX_W-1:0] rand_index(bit for_insert);
    int hi;
    hi = for_insert ? plan_count : plan_count - 1;
    if ($urandom_range(0, 9) == 0 || hi < 0) return oae_pkg::IDX_W'($urandom);
    if (for_insert && $urandom_range(0, 5) == 0) return '1;
    return oae_pkg::IDX_W'($urandom_range(0, hi));
  endfunction

  task automatic queue_random(int n);
    int r;
    logic [oae_pkg::OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      while (pending_reqs.size() > 8) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 32) op = oae_pkg::OP_INSERT;
      else if (r < 50) op = oae_pkg::OP_REMOVE;
      else if (r < 65) op = oae_pkg::OP_GET;
      else if (r < 75) op = oae_pkg::OP_PUT;
      else if (r < 87) op = oae_pkg::OP_SWAP;
      else if (r < 93) op = oae_pkg::OP_REVERSE;
      else if (r < 97) op = (plan_count <= 20) ? oae_pkg::OP_SORT : oae_pkg::OP_REVERSE;
      else op = oae_pkg::OP_CLEAR;
      queue_req(op, rand_index(op == oae_pkg::OP_INSERT),
                ($urandom_range(0, 9) == 0 || plan_count == 0) ? oae_pkg::IDX2_W'($urandom)
                  : oae_pkg::IDX2_W'($urandom_range(0, plan_count - 1)),
                rand_item());
    end
  endtask

  // Waits until the engine has nothing in flight, then writes the sort mode.
  task automatic drain_and_config(bit value);
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    mirror_signed = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain_and_config(1'b1);
    idle_pct = 28;
    // Empty array cases first, then sign extremes through a signed sort.
    queue_req(oae_pkg::OP_GET, '0, '0, '0);
    queue_req(oae_pkg::OP_REMOVE, '0, '0, '0);
    queue_req(oae_pkg::OP_REVERSE, '0, '0, '0);
    queue_req(oae_pkg::OP_SORT, '0, '0, '0);
    queue_req(oae_pkg::OP_INSERT, 7'd1, '0, 32'h1);
    queue_req(oae_pkg::OP_INSERT, 7'h7E, '0, 32'h1);
    queue_req(oae_pkg::OP_INSERT, '1, '0, 32'hFFFF_FFFF);
    queue_req(oae_pkg::OP_SORT, '0, '0, '0);
    queue_req(oae_pkg::OP_INSERT, '0, '0, 32'h8000_0000);
    queue_req(oae_pkg::OP_INSERT, '1, '0, 32'h7FFF_FFFF);
    queue_req(oae_pkg::OP_INSERT, 7'd3, '0, 32'h0);
    queue_req(oae_pkg::OP_INSERT, 7'd63, '0, 32'h5);
    queue_req(oae_pkg::OP_PUT, 7'd1, '0, 32'hFFFF_FFFE);
    queue_req(oae_pkg::OP_GET, 7'h40, '0, '0);
    queue_req(oae_pkg::OP_SWAP, 7'd0, 6'd3, '0);
    queue_req(oae_pkg::OP_SWAP, 7'd0, 6'd63, '0);
    queue_req(oae_pkg::OP_REVERSE, '0, '0, '0);
    queue_req(oae_pkg::OP_SORT, '0, '0, '0);
    queue_req(oae_pkg::OP_GET, 7'd0, '0, '0);
    queue_req(oae_pkg::OP_GET, 7'd3, '0, '0);
    queue_req(oae_pkg::OP_REMOVE, 7'd1, '0, '0);
    queue_req(oae_pkg::OP_PUT, 7'd3, '0, 32'h1);
    queue_req(oae_pkg::OP_CLEAR, '0, '0, '0);
    queue_random(400);
    drain_and_config(1'b0);
    idle_pct = 53;
    // Fill to the top, hit the full case, and sort the largest array once.
    for (int k = plan_count; k < oae_pkg::DEPTH; k++)
      queue_req(oae_pkg::OP_INSERT, '1, '0, rand_item());
    queue_req(oae_pkg::OP_INSERT, '0, '0, 32'h9);
    queue_req(oae_pkg::OP_INSERT, '1, '0, 32'h9);
    queue_req(oae_pkg::OP_SORT, '0, '0, '0);
    queue_req(oae_pkg::OP_REMOVE, 7'd63, '0, '0);
    queue_req(oae_pkg::OP_CLEAR, '0, '0, '0);
    queue_random(400);
    drain_and_config(1'b1);
    idle_pct = 0;
    queue_random(400);
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!start || taken)) begin
      taken = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        op_i <= pending_reqs[0].op;
        index_i <= pending_reqs[0].idx;
        second_index_i <= pending_reqs[0].idx2;
        write_data_i <= pending_reqs[0].data;
        void'(pending_reqs.pop_front());
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    array_req_t r;
    array_rsp_t e;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: count %0d", item_count_o);
        end else begin
          e = expected_rsps.pop_front();
          if (status_o !== e.status || read_data_o !== e.rdata || position_o !== e.pos ||
              item_count_o !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected st %0d rd %h pos %0d cnt %0d, got %0d %h %0d %0d",
                       e.status, e.rdata, e.pos, e.count,
                       status_o, read_data_o, position_o, item_count_o);
          end
        end
      end
      if (start && !busy) begin
        r.op = op_i;
        r.idx = index_i;
        r.idx2 = second_index_i;
        r.data = write_data_i;
        expected_rsps.push_back(apply_array_op(r));
        taken = 1'b1;
      end
    end
  end

endmodule
